// File: rtl/core/tcce_pkg.sv
// Shared types and constants for the travel cost cell encoder.
// Used by every module of the block but tcce_ram; depends on nothing.
`timescale 1ns / 1ps

package tcce_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_ENABLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP_LIMIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd3;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [30:0] COST_INVALID       = 31'h7FFF_FFFF;
    localparam logic [31:0] OFFSET_INVALID     = 32'h7FFF_FFFF;
    localparam logic [15:0] CODE_MAX_REACHABLE = 16'd65534;
    localparam logic [15:0] CODE_UNREACHABLE   = 16'd65535;

    // Reciprocal of ten for a 32-bit dividend: q = (t * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        CLASS_MAPPED         = 3'd0,
        CLASS_NO_CANDIDATE   = 3'd1,
        CLASS_NONE_REACHABLE = 3'd2,
        CLASS_SUM_INVALID    = 3'd3,
        CLASS_CAPPED         = 3'd4,
        CLASS_NODE_ERROR     = 3'd5
    } sample_class_t;

    typedef struct packed {
        logic               mode;
        logic [15:0]        load_index;
        logic [30:0]        load_cost;
        logic               fwd_present;
        logic [31:0]        fwd_node;
        logic               fwd_offset_ok;
        logic signed [31:0] fwd_offset;
        logic               rev_present;
        logic [31:0]        rev_node;
        logic               rev_offset_ok;
        logic signed [31:0] rev_offset;
    } item_t;

    typedef struct packed {
        logic [15:0]   cell_code;
        sample_class_t sample_class;
        logic [30:0]   best_cost;
    } result_t;

    // One candidate after the input stage, aligned with its table read.
    typedef struct packed {
        logic               present;
        logic               node_err;
        logic               offset_ok;
        logic signed [31:0] offset;
    } cand_t;

    // Chosen cost and class, handed from selection to encoding.
    typedef struct packed {
        logic          valid;
        logic [30:0]   best;
        sample_class_t cls;
    } pick_t;

endpackage

// File: rtl/core/tcce_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: rtl/core/tcce_select.sv
// Candidate sums, validity, minimum and class decision (two pipeline stages).
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_select
    import tcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s1_valid,
    input  cand_t       fwd,
    input  cand_t       rev,
    input  logic [30:0] fwd_cost,
    input  logic [30:0] rev_cost,
    input  logic        cap_enable,
    input  logic [30:0] cap_limit,
    output pick_t       pick
);

    typedef struct packed {
        logic        reach;
        logic        ok;
        logic        over_cap;
        logic [30:0] sum;
    } cand_sum_t;

    function automatic cand_sum_t eval_cand(cand_t c, logic [30:0] cost, logic [30:0] cap);
        cand_sum_t  r;
        logic [32:0] total;
        begin
            // Two's complement add of the unsigned cost and the signed offset.
            total      = {2'b00, cost} + {c.offset[31], c.offset};
            r.reach    = c.present && !c.node_err && (cost != COST_INVALID) && c.offset_ok;
            r.ok       = r.reach && (c.offset != OFFSET_INVALID) && !total[32]
                         && (total[31:0] < {1'b0, COST_INVALID});
            r.sum      = total[30:0];
            r.over_cap = total[30:0] > cap;
            return r;
        end
    endfunction

    cand_sum_t  fwd_sum;
    cand_sum_t  rev_sum;
    logic       s2_valid_reg;
    cand_sum_t  s2_fwd_reg;
    cand_sum_t  s2_rev_reg;
    logic       s2_present_reg;
    logic       s2_node_err_reg;

    logic          take_fwd;
    logic          best_ok;
    logic [30:0]   best_sum;
    logic          best_over;
    sample_class_t cls_next;
    logic [30:0]   best_next;
    logic          pick_valid_reg;
    logic [30:0]   pick_best_reg;
    sample_class_t pick_cls_reg;

    assign fwd_sum = eval_cand(fwd, fwd_cost, cap_limit);
    assign rev_sum = eval_cand(rev, rev_cost, cap_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_fwd_reg      <= fwd_sum;
        s2_rev_reg      <= rev_sum;
        s2_present_reg  <= fwd.present || rev.present;
        s2_node_err_reg <= fwd.node_err || rev.node_err;
    end

    always_comb
    begin
        take_fwd  = s2_fwd_reg.ok && (!s2_rev_reg.ok || (s2_fwd_reg.sum <= s2_rev_reg.sum));
        best_ok   = s2_fwd_reg.ok || s2_rev_reg.ok;
        best_sum  = take_fwd ? s2_fwd_reg.sum : s2_rev_reg.sum;
        best_over = take_fwd ? s2_fwd_reg.over_cap : s2_rev_reg.over_cap;
        best_next = best_ok ? best_sum : COST_INVALID;
        if (s2_node_err_reg)
        begin
            cls_next  = CLASS_NODE_ERROR;
            best_next = COST_INVALID;
        end
        else if (best_ok)
        begin
            cls_next = (cap_enable && best_over) ? CLASS_CAPPED : CLASS_MAPPED;
        end
        else if (!s2_present_reg)
        begin
            cls_next = CLASS_NO_CANDIDATE;
        end
        else if (!(s2_fwd_reg.reach || s2_rev_reg.reach))
        begin
            cls_next = CLASS_NONE_REACHABLE;
        end
        else
        begin
            cls_next = CLASS_SUM_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_valid_reg <= 1'b0;
        end
        else
        begin
            pick_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_best_reg <= best_next;
        pick_cls_reg  <= cls_next;
    end

    assign pick = {pick_valid_reg, pick_best_reg, pick_cls_reg};

endmodule

// File: rtl/core/tcce_encode.sv
// Cost to cell code conversion: divide by ten with round-half-to-even in duration mode, clip.
// Depends on tcce_pkg; two pipeline stages (multiply, then round and clip).
`timescale 1ns / 1ps

module tcce_encode
    import tcce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  pick_t   pick,
    input  logic    duration_mode,
    output logic    result_valid,
    output result_t result
);

    logic [63:0]   prod;
    logic          s4_valid_reg;
    logic [27:0]   s4_quot_reg;
    logic [30:0]   s4_best_reg;
    sample_class_t s4_cls_reg;

    logic [31:0] ten_q;
    logic [31:0] rem;
    logic        round_up;
    logic [28:0] quot_rounded;
    logic [30:0] value;
    logic [15:0] code;

    logic    result_valid_reg;
    result_t result_reg;

    assign prod = {32'd0, 1'b0, pick.best} * {32'd0, RECIP_TEN};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= pick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_quot_reg <= prod[RECIP_SHIFT+27:RECIP_SHIFT];
        s4_best_reg <= pick.best;
        s4_cls_reg  <= pick.cls;
    end

    always_comb
    begin
        ten_q        = 32'({s4_quot_reg, 3'b000}) + 32'({s4_quot_reg, 1'b0});
        rem          = {1'b0, s4_best_reg} - ten_q;
        round_up     = (rem[3:0] > 4'd5) || ((rem[3:0] == 4'd5) && s4_quot_reg[0]);
        quot_rounded = {1'b0, s4_quot_reg} + {28'd0, round_up};
        value        = duration_mode ? {2'b00, quot_rounded} : s4_best_reg;
        if (s4_cls_reg != CLASS_MAPPED)
        begin
            code = CODE_UNREACHABLE;
        end
        else if (value > {15'd0, CODE_MAX_REACHABLE})
        begin
            code = CODE_MAX_REACHABLE;
        end
        else
        begin
            code = value[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.cell_code    <= code;
        result_reg.sample_class <= s4_cls_reg;
        result_reg.best_cost    <= s4_best_reg;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/travel_cost_cell_encoder_core.sv
// Top level of the travel cost cell encoder: configuration registers, input
// stage and cost table. Depends on tcce_pkg, tcce_ram, tcce_select, tcce_encode.
`timescale 1ns / 1ps
//
// Usage:
//   A transaction enters when start is high and busy is low. With item.mode
//   low it writes item.load_cost into cost table entry item.load_index and
//   gives no result. With item.mode high it maps one sample: both candidate
//   nodes are read from the table, offsets are added, the smaller valid sum
//   is capped and converted, and one result follows.
//   Every result is shown on result for one cycle with result_valid high;
//   the receiver cannot hold it off, and none is needed.
//   Throughput: one transaction per cycle while busy is low, loads and samples mixed freely.
//   Pipeline: a sample's result is registered in turn after the table read,
//   the sums, the minimum and class, the multiply by the reciprocal of ten,
//   and the rounding and clip. A sample sees every load that was accepted
//   before it.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no sample is in flight.
//   Reset clears the pipeline and loads register reset values; busy stays
//   high for one cycle after reset. Table contents are undefined until written.

module travel_cost_cell_encoder_core
    import tcce_pkg::*;
#(
    parameter int MAX_NODES = 65536
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_NODES);

    logic        duration_mode_reg;
    logic        cap_enable_reg;
    logic [30:0] cap_limit_reg;
    logic [16:0] table_entries_reg;
    logic        busy_reg;

    logic        accept;
    logic [31:0] node_limit;
    logic [31:0] load_index_wide;
    logic        wr_en;
    cand_t       fwd_in;
    cand_t       rev_in;

    logic        s1_valid_reg;
    cand_t       s1_fwd_reg;
    cand_t       s1_rev_reg;
    logic [30:0] fwd_cost;
    logic [30:0] rev_cost;
    pick_t       pick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_mode_reg <= 1'b1;
            cap_enable_reg    <= 1'b0;
            cap_limit_reg     <= '0;
            table_entries_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DURATION_MODE: duration_mode_reg <= cfg_data[0];
                CFG_CAP_ENABLE:    cap_enable_reg    <= cfg_data[0];
                CFG_CAP_LIMIT:     cap_limit_reg     <= cfg_data[30:0];
                CFG_TABLE_ENTRIES: table_entries_reg <= cfg_data[16:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy_reg;

    // Node ids at or above the smaller of the entry count and the table depth
    // are errors.
    assign node_limit = (32'(table_entries_reg) < 32'(MAX_NODES))
                        ? 32'(table_entries_reg) : 32'(MAX_NODES);

    assign load_index_wide = {16'd0, item.load_index};
    assign wr_en = accept && (item.mode == MODE_LOAD) && (load_index_wide < 32'(MAX_NODES));

    always_comb
    begin
        fwd_in.present   = item.fwd_present;
        fwd_in.node_err  = item.fwd_present && (item.fwd_node >= node_limit);
        fwd_in.offset_ok = item.fwd_offset_ok;
        fwd_in.offset    = item.fwd_offset;
        rev_in.present   = item.rev_present;
        rev_in.node_err  = item.rev_present && (item.rev_node >= node_limit);
        rev_in.offset_ok = item.rev_offset_ok;
        rev_in.offset    = item.rev_offset;
    end

    tcce_ram #(
        .WIDTH (31),
        .DEPTH (MAX_NODES)
    ) u_cost_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (load_index_wide[ADDR_W-1:0]),
        .wr_data   (item.load_cost),
        .rd_addr_a (item.fwd_node[ADDR_W-1:0]),
        .rd_data_a (fwd_cost),
        .rd_addr_b (item.rev_node[ADDR_W-1:0]),
        .rd_data_b (rev_cost)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && (item.mode == MODE_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fwd_reg <= fwd_in;
        s1_rev_reg <= rev_in;
    end

    tcce_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .fwd        (s1_fwd_reg),
        .rev        (s1_rev_reg),
        .fwd_cost   (fwd_cost),
        .rev_cost   (rev_cost),
        .cap_enable (cap_enable_reg),
        .cap_limit  (cap_limit_reg),
        .pick       (pick)
    );

    tcce_encode u_encode (
        .clk           (clk),
        .rst_n         (rst_n),
        .pick          (pick),
        .duration_mode (duration_mode_reg),
        .result_valid  (result_valid),
        .result        (result)
    );

    // A result appears for each accepted sample, and never for a load.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid == $past(start && !busy && (item.mode == MODE_SAMPLE), 5))
        else $error("result strobe does not match accepted samples");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.sample_class != CLASS_MAPPED)
        |-> result.cell_code == CODE_UNREACHABLE)
        else $error("unmapped sample carries a reachable code");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.sample_class == CLASS_MAPPED)
        |-> (result.cell_code <= CODE_MAX_REACHABLE) && (result.best_cost != COST_INVALID))
        else $error("mapped sample has an invalid code or cost");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.sample_class == CLASS_NODE_ERROR)
                         || (result.sample_class == CLASS_NO_CANDIDATE)
                         || (result.sample_class == CLASS_NONE_REACHABLE)
                         || (result.sample_class == CLASS_SUM_INVALID))
        |-> result.best_cost == COST_INVALID)
        else $error("sample without a valid sum reports a cost");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for travel_cost_cell_encoder_core: load and sample
// transactions, with a cycle-accurate-free predictor of the cell code, class and best cost.
// Depends on tcce_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import tcce_pkg::*;

    localparam int TABLE_DEPTH   = 65536;
    localparam int TAIL_CYCLES   = 12;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 65;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    item_t                 item_in = '0;
    logic                  result_valid;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_DURATION_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies as the block holds them, starting from their reset values.
    logic        dur_mode_copy = 1'b1;
    logic        cap_en_copy = 1'b0;
    logic [30:0] cap_limit_copy = '0;
    logic [16:0] entries_copy = '0;
    logic [30:0] node_cost_copy [TABLE_DEPTH];

    // Table contents as planned by the stimulus, used to aim offsets and
    // to keep every in-range lookup on an entry that has been written.
    logic [30:0]  planned_cost [TABLE_DEPTH];
    bit           planned_written [TABLE_DEPTH];
    int unsigned  planned_nodes [$];
    longint       plan_limit;

    item_t   pending_items [$];
    result_t expected_cells [$];
    result_t want;
    int      fail_count = 0;
    int      idle_left = 0;
    int      run_left = 0;
    int      stall_cycles = 0;

    travel_cost_cell_encoder_core #(
        .MAX_NODES(TABLE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item_in),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] to_cell_code(input logic [30:0] cost);
        logic [31:0] q;
        logic [31:0] rem;
        q = {1'b0, cost};
        if (dur_mode_copy)
        begin
            q = cost / 10;
            rem = cost % 10;
            if (rem > 5 || (rem == 5 && q[0]))
                q = q + 1;
        end
        return (q > CODE_MAX_REACHABLE) ? CODE_MAX_REACHABLE : q[15:0];
    endfunction

    // Folds one candidate into the running minimum; id_err flags a bad node id.
    function automatic void score_candidate(input logic pres, input logic [31:0] node,
                                            input logic ok, input logic signed [31:0] off,
                                            inout bit seen, inout bit reach,
                                            inout logic [30:0] best, output bit id_err);
        longint      lim;
        logic [30:0] cost;
        longint      total;
        id_err = 1'b0;
        if (!pres)
            return;
        seen = 1'b1;
        lim = (entries_copy < TABLE_DEPTH) ? longint'(entries_copy) : longint'(TABLE_DEPTH);
        if (longint'(node) >= lim)
        begin
            id_err = 1'b1;
            return;
        end
        cost = node_cost_copy[node[15:0]];
        if (cost == COST_INVALID || !ok)
            return;
        reach = 1'b1;
        if (off == OFFSET_INVALID)
            return;
        total = longint'(cost) + longint'(off);
        if (total < 0 || total >= longint'(COST_INVALID))
            return;
        if (total < longint'(best))
            best = total[30:0];
    endfunction

    function automatic result_t encode_sample(input item_t it);
        result_t     r;
        bit          seen;
        bit          reach;
        bit          err_f;
        bit          err_r;
        logic [30:0] best;
        seen = 1'b0;
        reach = 1'b0;
        err_r = 1'b0;
        best = COST_INVALID;
        score_candidate(it.fwd_present, it.fwd_node, it.fwd_offset_ok, it.fwd_offset,
                        seen, reach, best, err_f);
        // A bad forward id decides the sample; the reverse side is not looked at.
        if (!err_f)
            score_candidate(it.rev_present, it.rev_node, it.rev_offset_ok, it.rev_offset,
                            seen, reach, best, err_r);
        r.cell_code = CODE_UNREACHABLE;
        r.best_cost = best;
        if (err_f || err_r)
        begin
            r.sample_class = CLASS_NODE_ERROR;
            r.best_cost = COST_INVALID;
        end
        else if (best != COST_INVALID)
        begin
            if (cap_en_copy && best > cap_limit_copy)
                r.sample_class = CLASS_CAPPED;
            else
            begin
                r.sample_class = CLASS_MAPPED;
                r.cell_code = to_cell_code(best);
            end
        end
        else if (!seen)
            r.sample_class = CLASS_NO_CANDIDATE;
        else if (!reach)
            r.sample_class = CLASS_NONE_REACHABLE;
        else
            r.sample_class = CLASS_SUM_INVALID;
        return r;
    endfunction

    function automatic item_t noise_item();
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return noise[$bits(item_t)-1:0];
    endfunction

    function automatic void plan_load(input logic [15:0] idx, input logic [30:0] cost);
        item_t it;
        it = noise_item();
        it.mode = MODE_LOAD;
        it.load_index = idx;
        it.load_cost = cost;
        pending_items = {pending_items, it};
        if (!planned_written[idx])
            planned_nodes = {planned_nodes, 32'(idx)};
        planned_written[idx] = 1'b1;
        planned_cost[idx] = cost;
    endfunction

    function automatic void plan_sample(input logic fp, input logic [31:0] fn, input logic fok,
                                        input logic signed [31:0] fo, input logic rp,
                                        input logic [31:0] rn, input logic rok,
                                        input logic signed [31:0] ro);
        item_t it;
        it = noise_item();
        it.mode = MODE_SAMPLE;
        it.fwd_present = fp;
        it.fwd_node = fn;
        it.fwd_offset_ok = fok;
        it.fwd_offset = fo;
        it.rev_present = rp;
        it.rev_node = rn;
        it.rev_offset_ok = rok;
        it.rev_offset = ro;
        pending_items = {pending_items, it};
    endfunction

    function automatic logic [15:0] draft_index();
        longint hot;
        hot = (plan_limit < 64) ? plan_limit : 64;
        if (hot > 0 && $urandom_range(0, 9) < 6)
            return 16'($urandom_range(0, 32'(hot - 1)));
        if ($urandom_range(0, 3) == 0)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [30:0] draft_cost();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: return 31'($urandom_range(0, 2000));
            8, 9, 10, 11, 12:       return 31'($urandom);
            13, 14:                 return COST_INVALID;
            15, 16:                 return COST_INVALID - 31'd1;
            default:                return 31'($urandom_range(655000, 656000));
        endcase
    endfunction

    // Present candidates either name a written entry below the table size or an
    // id at or past it; absent ones carry random ids.
    function automatic void draft_candidate(output logic pres, output logic [31:0] node,
                                            output logic ok, output logic signed [31:0] off);
        bit          hit;
        int unsigned pick;
        logic [30:0] cost;
        hit = 1'b0;
        cost = '0;
        pres = ($urandom_range(0, 9) != 0);
        node = $urandom;
        if (pres)
        begin
            if (planned_nodes.size() != 0 && $urandom_range(0, 9) < 8)
                for (int k = 0; k < 8 && !hit; k++)
                begin
                    pick = planned_nodes[$urandom_range(0, planned_nodes.size() - 1)];
                    if (longint'(pick) < plan_limit)
                    begin
                        hit = 1'b1;
                        node = pick;
                        cost = planned_cost[pick];
                    end
                end
            if (!hit)
            begin
                if ($urandom_range(0, 3) == 0)
                    node = 32'(plan_limit);
                else if ($urandom_range(0, 3) == 0)
                    node = 32'hFFFF_FFFF;
                if (longint'(node) < plan_limit)
                    node = 32'(plan_limit);
            end
        end
        ok = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0, 1, 2: off = $signed($urandom_range(0, 2000)) - 1000;
            3, 4:    off = $urandom;
            5:       off = OFFSET_INVALID;
            6:       off = 32'sh8000_0000;
            7:       off = -$signed({1'b0, cost});
            8:       off = $signed({1'b0, COST_INVALID - 31'd1 - cost}
                                   + 32'($urandom_range(0, 1)));
            default: off = 0;
        endcase
    endfunction

    // Called right after a rising edge; leaves cfg_valid high for the caller.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DURATION_MODE: dur_mode_copy = data[0];
            CFG_CAP_ENABLE:    cap_en_copy = data[0];
            CFG_CAP_LIMIT:     cap_limit_copy = data[30:0];
            CFG_TABLE_ENTRIES: entries_copy = data[16:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic dm, input logic ce, input logic [30:0] cl,
                                input logic [16:0] te);
        write_reg(CFG_DURATION_MODE, {31'd0, dm});
        write_reg(CFG_CAP_ENABLE, {31'd0, ce});
        write_reg(CFG_CAP_LIMIT, {1'b0, cl});
        write_reg(CFG_TABLE_ENTRIES, {15'd0, te});
        cfg_valid <= 1'b0;
        plan_limit = (te < TABLE_DEPTH) ? longint'(te) : longint'(TABLE_DEPTH);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || start || expected_cells.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic int draw_gap();
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            run_left = $urandom_range(10, 30);
        return $urandom_range(0, 14);
    endfunction

    // Driver: a transaction is taken when start is high and busy is low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (item_in.mode == MODE_SAMPLE)
                    expected_cells = {expected_cells, encode_sample(item_in)};
                else
                    node_cost_copy[item_in.load_index] = item_in.load_cost;
                idle_left = draw_gap();
            end
            if (!start || !busy)
            begin
                if (idle_left == 0 && pending_items.size() != 0)
                begin
                    start <= 1'b1;
                    item_in <= pending_items.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                    if (idle_left > 0)
                        idle_left--;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_cells.size() == 0)
            begin
                $error("unexpected result: cell_code %0d, sample_class %0d, best_cost %0d",
                       result.cell_code, result.sample_class, result.best_cost);
                fail_count++;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (result.cell_code !== want.cell_code)
                begin
                    $error("cell_code: expected %0d, actual %0d",
                           want.cell_code, result.cell_code);
                    fail_count++;
                end
                if (result.sample_class !== want.sample_class)
                begin
                    $error("sample_class: expected %0d, actual %0d",
                           want.sample_class, result.sample_class);
                    fail_count++;
                end
                if (result.best_cost !== want.best_cost)
                begin
                    $error("best_cost: expected %0d, actual %0d",
                           want.best_cost, result.best_cost);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction of any kind moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic        dm;
        logic        ce;
        logic [30:0] cl;
        logic [16:0] te;
        logic        fp;
        logic        fok;
        logic        rp;
        logic        rok;
        logic [31:0] fn;
        logic [31:0] rn;
        logic signed [31:0] fo;
        logic signed [31:0] ro;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Duration mode, no cap, full table: rounding, clipping and every class but capped.
        program_regs(1'b1, 1'b0, 31'd0, 17'd65536);
        plan_load(16'd0, 31'd0);
        plan_load(16'd1, COST_INVALID - 31'd1);
        plan_load(16'd2, 31'd15);
        plan_load(16'd3, 31'd25);
        plan_load(16'd4, 31'd655349);
        plan_load(16'hFFFF, COST_INVALID);
        plan_sample(1'b0, 32'd0, 1'b1, 0, 1'b0, 32'd1, 1'b1, 0);
        plan_sample(1'b1, 32'd65535, 1'b1, 0, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd0, 1'b0, 0, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd0, 1'b1, OFFSET_INVALID, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd1, 1'b1, 1, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd1, 1'b1, 32'sh8000_0000, 1'b1, 32'd2, 1'b1, -16);
        plan_sample(1'b1, 32'd2, 1'b1, 0, 1'b1, 32'd3, 1'b1, 0);
        plan_sample(1'b1, 32'd4, 1'b1, 0, 1'b1, 32'd65535, 1'b1, 0);
        plan_sample(1'b1, 32'd1, 1'b1, 0, 1'b1, 32'd0, 1'b1, 5);
        plan_sample(1'b1, 32'd70000, 1'b1, 0, 1'b1, 32'd0, 1'b1, 0);
        plan_sample(1'b0, 32'd0, 1'b1, 0, 1'b1, 32'hFFFF_FFFF, 1'b1, 0);
        drain();

        // Raw ticks with a small cap: at the cap, just above it, and far above.
        program_regs(1'b0, 1'b1, 31'd50, 17'd65536);
        plan_sample(1'b1, 32'd2, 1'b1, 35, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd2, 1'b1, 36, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd1, 1'b1, 0, 1'b0, 32'd0, 1'b1, 0);
        drain();

        // One table entry and the largest cap: raw clipping and an id just past the end.
        program_regs(1'b0, 1'b1, COST_INVALID - 31'd1, 17'd1);
        plan_sample(1'b1, 32'd1, 1'b1, 0, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd0, 1'b1, 32'sd2147483646, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b1, 32'd0, 1'b1, 65534, 1'b1, 32'd0, 1'b1, 65535);
        drain();

        // Empty table: any present candidate is an id error.
        program_regs(1'b1, 1'b1, 31'd0, 17'd0);
        plan_sample(1'b1, 32'd0, 1'b1, 0, 1'b0, 32'd0, 1'b1, 0);
        plan_sample(1'b0, 32'd0, 1'b1, 0, 1'b0, 32'd0, 1'b1, 0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            dm = 1'($urandom_range(0, 1));
            ce = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       cl = 31'd0;
                1:       cl = COST_INVALID - 31'd1;
                2:       cl = 31'($urandom_range(0, 3000));
                default: cl = 31'($urandom_range(0, 32'd2147483646));
            endcase
            case ($urandom_range(0, 2))
                0:       te = 17'd65536;
                1:       te = 17'($urandom_range(1, 64));
                default: te = 17'($urandom_range(65, 65536));
            endcase
            program_regs(dm, ce, cl, te);
            // Fill some entries first so that most samples find real costs.
            for (int n = 0; n < 8; n++)
                plan_load(draft_index(), draft_cost());
            for (int n = 8; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                    plan_load(draft_index(), draft_cost());
                else
                begin
                    draft_candidate(fp, fn, fok, fo);
                    draft_candidate(rp, rn, rok, ro);
                    plan_sample(fp, fn, fok, fo, rp, rn, rok, ro);
                end
            end
            drain();
        end

        if (expected_cells.size() != 0)
        begin
            $error("%0d results never arrived", expected_cells.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
